// ===== hdl/btsh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bit-sliced ternary sponge hash unit.
// No dependencies; imported by the controller, the datapath and the top level.
package btsh_pkg;

	localparam int WORD_W      = 64;
	localparam int ELEM_W      = 2 * WORD_W;
	localparam int STATE_TRITS = 729;
	localparam int STEP_FWD    = 364;
	localparam int ROUNDS_DEF  = 81;
	localparam int RATE_DEF    = 243;

	localparam int ADDR_W = 10;
	localparam int CNT_W  = 10;
	localparam int POS_W  = 8;
	localparam int RND_W  = 8;

	// One round sweeps STATE_TRITS + 1 reads; the last write lands in the cycle
	// after the last read, so the in-round counter runs from 0 to PERM_LAST.
	localparam int PERM_LAST = STATE_TRITS + 1;

	localparam logic [1:0] CMD_ABSORB  = 2'd0;
	localparam logic [1:0] CMD_SQUEEZE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	typedef struct packed {
		logic              absorb_we;
		logic              sqz_rd;
		logic              clr_we;
		logic              perm_rd;
		logic              perm_first;
		logic              perm_wr;
		logic              flip;
		logic              load_out;
		logic [ADDR_W-1:0] addr;
	} dp_cmd_t;

endpackage

// ===== hdl/btsh_dp.sv =====
`timescale 1ns / 1ps
// Datapath: two ping-pong state memories, the round function and the output register.
// Depends on btsh_pkg; driven by btsh_ctrl through dp_cmd_t.
module btsh_dp import btsh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           dp_ctl,
	input  logic [WORD_W-1:0] low_word,
	input  logic [WORD_W-1:0] high_word,
	output logic [WORD_W-1:0] out_low,
	output logic [WORD_W-1:0] out_high
);

	logic [ELEM_W-1:0] mem0 [0:STATE_TRITS-1];
	logic [ELEM_W-1:0] mem1 [0:STATE_TRITS-1];

	logic              bank_q;
	logic [ADDR_W-1:0] paddr_q;
	logic [ELEM_W-1:0] rd0_q;
	logic [ELEM_W-1:0] rd1_q;
	logic [ELEM_W-1:0] prev_q;
	logic [WORD_W-1:0] out_low_q;
	logic [WORD_W-1:0] out_high_q;

	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W:0]   psum;
	logic [ADDR_W-1:0] pnext;
	logic              rd_en;
	logic [ELEM_W-1:0] rd_data;
	logic [ELEM_W-1:0] cell_val;
	logic [ELEM_W-1:0] wdata;
	logic              we_cur;
	logic              we0;
	logic              we1;

	// Cell inputs: a, b from the earlier position, c, g from the later one.
	logic [WORD_W-1:0] a, b, c, g, d;

	assign raddr = dp_ctl.perm_rd ? (dp_ctl.perm_first ? '0 : paddr_q) : dp_ctl.addr;
	assign psum  = {1'b0, raddr} + (ADDR_W+1)'(STEP_FWD);
	assign pnext = (psum >= (ADDR_W+1)'(STATE_TRITS)) ?
		ADDR_W'(psum - (ADDR_W+1)'(STATE_TRITS)) : psum[ADDR_W-1:0];
	assign rd_en = dp_ctl.perm_rd | dp_ctl.sqz_rd;

	assign rd_data = bank_q ? rd1_q : rd0_q;

	assign a        = prev_q[WORD_W-1:0];
	assign b        = prev_q[ELEM_W-1:WORD_W];
	assign c        = rd_data[WORD_W-1:0];
	assign g        = rd_data[ELEM_W-1:WORD_W];
	assign d        = (a | ~g) & (c ^ b);
	assign cell_val = {(a ^ g) | d, ~d};

	always_comb begin
		if (dp_ctl.perm_wr) begin
			wdata = cell_val;
		end else if (dp_ctl.clr_we) begin
			wdata = '1;
		end else begin
			wdata = {high_word, low_word};
		end
	end

	// Absorb and clear go to the live bank; the permutation fills the other one.
	assign we_cur = dp_ctl.absorb_we | dp_ctl.clr_we;
	assign we0    = (we_cur & ~bank_q) | (dp_ctl.perm_wr & bank_q);
	assign we1    = (we_cur & bank_q) | (dp_ctl.perm_wr & ~bank_q);

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[dp_ctl.addr] <= wdata;
		end
		if (rd_en) begin
			rd0_q <= mem0[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[dp_ctl.addr] <= wdata;
		end
		if (rd_en) begin
			rd1_q <= mem1[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			paddr_q <= '0;
		end else begin
			if (dp_ctl.flip) begin
				bank_q <= ~bank_q;
			end
			if (dp_ctl.perm_rd) begin
				paddr_q <= pnext;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctl.perm_rd | dp_ctl.perm_wr) begin
			prev_q <= rd_data;
		end
		if (dp_ctl.load_out) begin
			out_low_q  <= rd_data[WORD_W-1:0];
			out_high_q <= rd_data[ELEM_W-1:WORD_W];
		end
	end

	assign out_low  = out_low_q;
	assign out_high = out_high_q;

endmodule

// ===== hdl/btsh_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: state machine for clear, absorb/squeeze and the permutation rounds.
// Depends on btsh_pkg; drives btsh_dp through dp_cmd_t.
module btsh_ctrl import btsh_pkg::*; #(
	parameter int ROUNDS     = ROUNDS_DEF,
	parameter int RATE_TRITS = RATE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    dp_ctl
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SQZ, S_PERM} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RND_W-1:0] round_q;
	logic [POS_W-1:0] pos_q;
	logic             perm_pend_q;
	logic             out_valid_q;

	logic             accept;
	logic [POS_W:0]   pos_inc;
	logic             wrap;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign pos_inc   = {1'b0, pos_q} + (POS_W+1)'(1);
	assign wrap      = last | (pos_inc >= (POS_W+1)'(RATE_TRITS));
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		dp_ctl = '0;
		case (state_q)
			S_CLEAR: begin
				dp_ctl.clr_we = 1'b1;
				dp_ctl.addr   = ADDR_W'(cnt_q);
			end
			S_IDLE: begin
				dp_ctl.addr      = ADDR_W'(pos_q);
				dp_ctl.absorb_we = accept & (cmd == CMD_ABSORB);
				dp_ctl.sqz_rd    = accept & (cmd == CMD_SQUEEZE);
			end
			S_SQZ: begin
				dp_ctl.load_out = out_free;
			end
			S_PERM: begin
				dp_ctl.perm_rd    = (cnt_q <= CNT_W'(STATE_TRITS));
				dp_ctl.perm_first = (cnt_q == '0);
				dp_ctl.perm_wr    = (cnt_q >= CNT_W'(2));
				dp_ctl.addr       = ADDR_W'(cnt_q - CNT_W'(2));
				dp_ctl.flip       = (cnt_q == CNT_W'(PERM_LAST));
			end
			default: begin
				dp_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			round_q     <= '0;
			pos_q       <= '0;
			perm_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(STATE_TRITS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_ABSORB: begin
								pos_q <= wrap ? '0 : pos_inc[POS_W-1:0];
								if (wrap) begin
									cnt_q   <= '0;
									round_q <= '0;
									state_q <= S_PERM;
								end
							end
							CMD_SQUEEZE: begin
								pos_q       <= wrap ? '0 : pos_inc[POS_W-1:0];
								perm_pend_q <= wrap;
								state_q     <= S_SQZ;
							end
							CMD_CLEAR: begin
								pos_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				S_SQZ: begin
					if (out_free) begin
						cnt_q   <= '0;
						round_q <= '0;
						state_q <= perm_pend_q ? S_PERM : S_IDLE;
					end
				end
				S_PERM: begin
					if (cnt_q == CNT_W'(PERM_LAST)) begin
						cnt_q <= '0;
						if (round_q == RND_W'(ROUNDS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							round_q <= round_q + RND_W'(1);
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/bitsliced_ternary_sponge_hash_unit.sv =====
`timescale 1ns / 1ps
// Top level of the 64-lane bit-sliced ternary sponge hash unit.
// Depends on btsh_pkg, btsh_ctrl and btsh_dp.

// The unit keeps a 729-position ternary sponge state, each position holding one
// trit per lane as a low/high bit pair, in two 729 x 128-bit memories used as a
// ping-pong pair. An absorb item (cmd 0) overwrites the element at the current
// rate position; a squeeze item (cmd 1) returns that element through the
// registered memory read and then the load of the output register, which waits
// until the previous result has been taken. Absorb items are taken while a
// result still waits. After RATE_TRITS items, or after an item marked last, the
// unit runs ROUNDS rounds of the permutation: each round streams the state out
// of one memory along the 364-step position sequence, one read per cycle, and
// writes the new cells into the other memory. A reset command (cmd 2), and also
// the release of arst_n, starts a clearing pass that writes all ones into the
// live memory, one position per cycle; no item is accepted during a permutation
// or a clearing pass. Command code 3 is accepted and ignored.
module bitsliced_ternary_sponge_hash_unit import btsh_pkg::*; #(
	parameter int ROUNDS     = ROUNDS_DEF,
	parameter int RATE_TRITS = RATE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [WORD_W-1:0] low_word,
	input  logic [WORD_W-1:0] high_word,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_low,
	output logic [WORD_W-1:0] out_high
);

	dp_cmd_t dp_ctl;

	btsh_ctrl #(
		.ROUNDS     (ROUNDS),
		.RATE_TRITS (RATE_TRITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_ctl    (dp_ctl)
	);

	btsh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_ctl    (dp_ctl),
		.low_word  (low_word),
		.high_word (high_word),
		.out_low   (out_low),
		.out_high  (out_high)
	);

	// A squeeze item holds off the input for at least the cycle of its output load.
	a_sqz_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_SQUEEZE) |=> !in_ready)
		else $error("input accepted right after a squeeze item");

	// Permutation writes never overlap with an accepted item.
	a_perm_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ctl.perm_wr |-> !in_ready)
		else $error("input ready during a permutation write");

	// A result only appears after the output register was loaded.
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(dp_ctl.load_out))
		else $error("out_valid rose without an output load");

endmodule
